@@ hw/rtl/psed_pkg.sv @@
// ---------------------------------------------------------------------------
// psed_pkg
// Shared types and constants of the phase-shift electrode driver.
// ---------------------------------------------------------------------------
`default_nettype none

package psed_pkg;

  // Input word field widths
  localparam int KIND_W  = 3;
  localparam int INDEX_W = 5;
  localparam int LEVEL_W = 10;

  // Command codes
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 3'd0,
    KIND_SET_ROW = 3'd1,
    KIND_SET_COL = 3'd2,
    KIND_ALL_OFF = 3'd3,
    KIND_READ    = 3'd4
  } kind_t;

  // Level scale: 1000 tenths of a percent is full transmission
  localparam int unsigned LEVEL_FULL = 1000;

  // Level to delta: round(steps * level / 2000).
  // Numerator steps*level + 1000 stays below 2^18 for steps up to 256.
  localparam int DELTA_NUM_W = 18;
  // Divide by 2000 = shift by 4, then exact reciprocal multiply for /125.
  localparam int DELTA_PRE_SHIFT = 4;
  localparam int DELTA_Y_W       = DELTA_NUM_W - DELTA_PRE_SHIFT;
  localparam int RECIP_W         = 15;
  localparam logic [RECIP_W-1:0] RECIP_125 = 15'd16778;  // ceil(2^21 / 125)
  localparam int RECIP_SHIFT     = 21;
  localparam int PROD_W          = DELTA_Y_W + RECIP_W;
  localparam int QUOT_W          = PROD_W - RECIP_SHIFT;

endpackage : psed_pkg

`default_nettype wire

@@ hw/rtl/psed_delta.sv @@
// ---------------------------------------------------------------------------
// psed_delta
// Converts a transmission level into a phase delta, saturating at half a period.
// ---------------------------------------------------------------------------
`default_nettype none

module psed_delta #(
  parameter int PWM_STEPS = 16,
  parameter int PW        = 4
) (
  input  wire logic [psed_pkg::LEVEL_W-1:0] level,
  output logic      [PW-1:0]                delta
);

  logic [psed_pkg::DELTA_NUM_W-1:0] num;
  logic [psed_pkg::DELTA_Y_W-1:0]   y;
  logic [psed_pkg::PROD_W-1:0]      prod;
  logic [psed_pkg::QUOT_W-1:0]      quot;

  // num / 2000 == (num >> 4) / 125, exact reciprocal for the 14-bit range
  assign num  = psed_pkg::DELTA_NUM_W'(PWM_STEPS) * psed_pkg::DELTA_NUM_W'(level)
              + psed_pkg::DELTA_NUM_W'(psed_pkg::LEVEL_FULL);
  assign y    = num[psed_pkg::DELTA_NUM_W-1:psed_pkg::DELTA_PRE_SHIFT];
  assign prod = psed_pkg::PROD_W'(y) * psed_pkg::PROD_W'(psed_pkg::RECIP_125);
  assign quot = prod[psed_pkg::PROD_W-1:psed_pkg::RECIP_SHIFT];

  always_comb begin
    if (32'(level) >= psed_pkg::LEVEL_FULL) begin
      delta = PW'(PWM_STEPS / 2);
    end else begin
      delta = PW'(quot);
    end
  end

endmodule : psed_delta

`default_nettype wire

@@ hw/rtl/psed_wave.sv @@
// ---------------------------------------------------------------------------
// psed_wave
// Square-wave comparators: one level per channel from tick and phase.
// ---------------------------------------------------------------------------
`default_nettype none

module psed_wave #(
  parameter int PWM_STEPS = 16,
  parameter int PW        = 4,
  parameter int CH        = 22
) (
  input  wire logic [PW-1:0]    tick,
  input  wire logic [CH*PW-1:0] phases,
  output logic      [CH-1:0]    levels
);

  for (genvar i = 0; i < CH; i++) begin : g_ch
    logic [PW-1:0] ph;
    logic [PW:0]   pos;

    assign ph = phases[i*PW +: PW];

    // (tick - phase) mod steps, phase and tick both below steps
    always_comb begin
      if (tick >= ph) begin
        pos = {1'b0, tick} - {1'b0, ph};
      end else begin
        pos = {1'b0, tick} + (PW+1)'(PWM_STEPS) - {1'b0, ph};
      end
    end

    assign levels[i] = (pos < (PW+1)'(PWM_STEPS / 2));
  end

endmodule : psed_wave

`default_nettype wire

@@ hw/rtl/phase_shift_electrode_driver_top.sv @@
// ---------------------------------------------------------------------------
// phase_shift_electrode_driver_top
// Phase-shifted 50% square-wave drive for column and row electrodes.
// ---------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_stall  | kind, index, level
//  out     | out_valid/out_stall| column_levels, row_levels, phase_value,
//          |                    | rejected
//
//  One word per cycle sustained while the result is not stalled. Words pass
//  through an input register, then the command logic (comparators,
//  level-to-delta multiply, phase table update) feeding the result register.
//  Synchronous active-high reset clears the phase table, tick and levels.
//  A stalled result holds; the input register keeps taking words as long
//  as the result register is empty or is being drained in the same cycle.
//
`default_nettype none

module phase_shift_electrode_driver_top #(
  parameter int PWM_STEPS = 16,
  parameter int COLUMNS   = 15,
  parameter int ROWS      = 7
) (
  input  wire logic                         clk,
  input  wire logic                         rst,

  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [psed_pkg::KIND_W-1:0]  kind,
  input  wire logic [psed_pkg::INDEX_W-1:0] index,
  input  wire logic [psed_pkg::LEVEL_W-1:0] level,

  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [COLUMNS-1:0]           column_levels,
  output logic      [ROWS-1:0]              row_levels,
  output logic      [$clog2(PWM_STEPS)-1:0] phase_value,
  output logic                              rejected
);

  localparam int PW  = $clog2(PWM_STEPS);
  localparam int CH  = COLUMNS + ROWS;
  localparam int CIW = (CH > 1) ? $clog2(CH) : 1;

  // Input register
  logic                         s1_valid;
  logic [psed_pkg::KIND_W-1:0]  s1_kind;
  logic [psed_pkg::INDEX_W-1:0] s1_index;
  logic [psed_pkg::LEVEL_W-1:0] s1_level;
  logic                         advance;

  // Block state
  logic [PW-1:0] phase_table      [CH];
  logic [PW-1:0] phase_table_next [CH];
  logic [PW-1:0] tick;
  logic [PW-1:0] tick_next;
  logic [CH-1:0] drive_levels;
  logic [CH-1:0] drive_levels_next;

  logic [PW-1:0] phase_value_next;
  logic          rejected_next;

  // Datapath helpers
  logic [CH*PW-1:0] phases_flat;
  logic [CH-1:0]    wave_levels;
  logic [PW-1:0]    delta;
  logic [PW-1:0]    ref_phase;
  logic [PW:0]      shift_sum;
  logic [PW-1:0]    shifted;
  logic [CIW-1:0]   rd_sel;
  logic             rd_ok;
  logic             row_ok;
  logic             col_ok;

  // Pipeline control: stage 1 moves on when the result slot frees up
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind  <= kind;
      s1_index <= index;
      s1_level <= level;
    end
  end

  // Comparators run on the current tick and table
  for (genvar i = 0; i < CH; i++) begin : g_flat
    assign phases_flat[i*PW +: PW] = phase_table[i];
  end

  psed_wave #(
    .PWM_STEPS (PWM_STEPS),
    .PW        (PW),
    .CH        (CH)
  ) u_wave (
    .tick   (tick),
    .phases (phases_flat),
    .levels (wave_levels)
  );

  psed_delta #(
    .PWM_STEPS (PWM_STEPS),
    .PW        (PW)
  ) u_delta (
    .level (s1_level),
    .delta (delta)
  );

  // Reference: column 1 for a row shift, row 1 for a column shift
  assign ref_phase = (psed_pkg::kind_t'(s1_kind) == psed_pkg::KIND_SET_ROW)
                   ? phase_table[0] : phase_table[COLUMNS];
  assign shift_sum = {1'b0, ref_phase} + {1'b0, delta};
  assign shifted   = (shift_sum >= (PW+1)'(PWM_STEPS))
                   ? PW'(shift_sum - (PW+1)'(PWM_STEPS)) : PW'(shift_sum);

  assign row_ok = (s1_index != '0) && (32'(s1_index) <= ROWS);
  assign col_ok = (s1_index != '0) && (32'(s1_index) <= COLUMNS);
  assign rd_ok  = (32'(s1_index) < CH);
  assign rd_sel = CIW'(s1_index);

  always_comb begin
    phase_table_next  = phase_table;
    tick_next         = tick;
    drive_levels_next = drive_levels;
    phase_value_next  = '0;
    rejected_next     = 1'b0;

    unique case (psed_pkg::kind_t'(s1_kind))
      psed_pkg::KIND_TICK: begin
        drive_levels_next = wave_levels;
        tick_next = (tick == PW'(PWM_STEPS - 1)) ? '0 : tick + PW'(1);
      end
      psed_pkg::KIND_SET_ROW: begin
        if (row_ok) begin
          for (int i = 0; i < CH; i++) begin
            phase_table_next[i] = (i == COLUMNS + int'(s1_index) - 1) ? shifted : ref_phase;
          end
        end else begin
          rejected_next = 1'b1;
        end
      end
      psed_pkg::KIND_SET_COL: begin
        if (col_ok) begin
          for (int i = 0; i < CH; i++) begin
            phase_table_next[i] = (i == int'(s1_index) - 1) ? shifted : ref_phase;
          end
        end else begin
          rejected_next = 1'b1;
        end
      end
      psed_pkg::KIND_ALL_OFF: begin
        for (int i = 0; i < CH; i++) begin
          phase_table_next[i] = phase_table[0];
        end
      end
      psed_pkg::KIND_READ: begin
        if (rd_ok) begin
          phase_value_next = phase_table[rd_sel];
        end
      end
      default: begin
        // unused codes leave everything as is
      end
    endcase
  end

  // State commits as the word moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CH; i++) begin
        phase_table[i] <= '0;
      end
      tick         <= '0;
      drive_levels <= '0;
    end else if (advance) begin
      phase_table  <= phase_table_next;
      tick         <= tick_next;
      drive_levels <= drive_levels_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      column_levels <= drive_levels_next[COLUMNS-1:0];
      row_levels    <= drive_levels_next[CH-1:COLUMNS];
      phase_value   <= phase_value_next;
      rejected      <= rejected_next;
    end
  end

endmodule : phase_shift_electrode_driver_top

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the phase-shift electrode driver. Directed words
// cover line-index limits, level rounding and saturation, all-off, unused
// kinds and reads. Random words then run under three idle mixes and one
// long output hold-off. Every result is compared per field against an
// in-bench model of the phase table, tick counter and latched drive levels.
// ---------------------------------------------------------------------------

module tb_top;

  // Geometry of the block under test
  localparam int STEPS    = 16;
  localparam int HALF     = STEPS / 2;
  localparam int NUM_COLS = 15;
  localparam int NUM_ROWS = 7;
  localparam int NUM_CHAN = NUM_COLS + NUM_ROWS;
  localparam int PH_W     = $clog2(STEPS);

  localparam int LEVEL_MAX = (1 << psed_pkg::LEVEL_W) - 1;
  localparam int INDEX_MAX = (1 << psed_pkg::INDEX_W) - 1;

  // Field types of one command word
  typedef logic [psed_pkg::KIND_W-1:0]  kind_code_t;
  typedef logic [psed_pkg::INDEX_W-1:0] idx_t;
  typedef logic [psed_pkg::LEVEL_W-1:0] lvl_t;

  // Kinds the block ignores
  localparam kind_code_t KIND_SPARE_LO = 3'd5;
  localparam kind_code_t KIND_SPARE_HI = 3'd7;

  localparam int HOLD_CYCLES  = 300;      // long output hold-off
  localparam int END_LATENCY  = 10;       // cycles to wait after the last result
  localparam int LIMIT_CYCLES = 400000;   // run watchdog

  // One result word
  typedef struct packed {
    logic [NUM_COLS-1:0] cols;
    logic [NUM_ROWS-1:0] rows;
    logic [PH_W-1:0]     phase;
    logic                rej;
  } drive_word_t;

  // One command word
  typedef struct packed {
    kind_code_t k;
    idx_t       idx;
    lvl_t       lvl;
  } drive_cmd_t;

  // -------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // -------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  kind_code_t          kind      = '0;
  idx_t                index     = '0;
  lvl_t                level     = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [NUM_COLS-1:0] column_levels;
  logic [NUM_ROWS-1:0] row_levels;
  logic [PH_W-1:0]     phase_value;
  logic                rejected;

  phase_shift_electrode_driver_top #(
    .PWM_STEPS (STEPS),
    .COLUMNS   (NUM_COLS),
    .ROWS      (NUM_ROWS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .index         (index),
    .level         (level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .column_levels (column_levels),
    .row_levels    (row_levels),
    .phase_value   (phase_value),
    .rejected      (rejected)
  );

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Model state: phase per channel, running tick, latched levels
  // -------------------------------------------------------------------------
  logic [PH_W-1:0]     phase_tab [NUM_CHAN];
  logic [PH_W-1:0]     tick_pos;
  logic [NUM_CHAN-1:0] drive_lv;
  drive_word_t         expected_words [$];

  // Idle mix; percentages per cycle
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Hold-off requests from the test side, served by the receiver process
  int hold_reqs   = 0;
  int hold_served = 0;
  int hold_left   = 0;

  // Bookkeeping
  int mismatch_count = 0;
  int words_sent     = 0;
  int results_seen   = 0;
  int tick_count     = 0;
  int set_count      = 0;
  int reject_count   = 0;
  int read_count     = 0;
  int other_count    = 0;
  int cycle_count    = 0;

  // -------------------------------------------------------------------------
  // Apply one accepted word to the model and queue the result it must give.
  // -------------------------------------------------------------------------
  function automatic void update_phase_model(kind_code_t k, idx_t idx, lvl_t lvl);
    drive_word_t     w;
    logic [PH_W-1:0] ref_ph;
    int unsigned     delta;
    int unsigned     target;
    int unsigned     pos;
    bit              align;
    w      = '0;
    align  = 1'b0;
    ref_ph = '0;
    target = NUM_CHAN;  // no line shifted unless a set picks one
    // round half up; saturate at half a period
    delta  = (lvl >= psed_pkg::LEVEL_FULL) ? HALF
           : (STEPS * lvl + psed_pkg::LEVEL_FULL) / (2 * psed_pkg::LEVEL_FULL);
    case (k)
      psed_pkg::KIND_TICK: begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
          pos = (tick_pos + STEPS - phase_tab[ch]) % STEPS;
          drive_lv[ch] = (pos < HALF);
        end
        tick_pos = PH_W'((tick_pos + 1) % STEPS);
        tick_count++;
      end
      psed_pkg::KIND_SET_ROW: begin
        set_count++;
        if (idx < 1 || idx > NUM_ROWS) begin
          w.rej = 1'b1;
          reject_count++;
        end else begin
          align  = 1'b1;
          ref_ph = phase_tab[0];
          target = NUM_COLS + idx - 1;
        end
      end
      psed_pkg::KIND_SET_COL: begin
        set_count++;
        if (idx < 1 || idx > NUM_COLS) begin
          w.rej = 1'b1;
          reject_count++;
        end else begin
          align  = 1'b1;
          ref_ph = phase_tab[NUM_COLS];
          target = idx - 1;
        end
      end
      psed_pkg::KIND_ALL_OFF: begin
        align  = 1'b1;
        ref_ph = phase_tab[0];
        other_count++;
      end
      psed_pkg::KIND_READ: begin
        read_count++;
        if (idx < NUM_CHAN) w.phase = phase_tab[idx];
      end
      default: other_count++;
    endcase
    if (align) begin
      for (int ch = 0; ch < NUM_CHAN; ch++) phase_tab[ch] = ref_ph;
      if (target < NUM_CHAN) phase_tab[target] = PH_W'((ref_ph + delta) % STEPS);
    end
    w.cols = drive_lv[NUM_COLS-1:0];
    w.rows = drive_lv[NUM_CHAN-1:NUM_COLS];
    expected_words.push_back(w);
  endfunction

  // -------------------------------------------------------------------------
  // Sender: optional idle cycles, then offer the word until taken
  // -------------------------------------------------------------------------
  task automatic send_word(kind_code_t k, idx_t idx, lvl_t lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    index    <= idx;
    level    <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    update_phase_model(k, idx, lvl);
    words_sent++;
  endtask

  // Stop offering and wait until every queued result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  // Mostly well-formed commands; a share of bad indexes and ignored kinds
  function automatic drive_cmd_t random_cmd();
    drive_cmd_t c;
    int         pick;
    pick  = $urandom_range(99);
    c.idx = idx_t'($urandom_range(INDEX_MAX));
    if (pick < 40) c.k = psed_pkg::KIND_TICK;
    else if (pick < 55) c.k = psed_pkg::KIND_SET_ROW;
    else if (pick < 70) c.k = psed_pkg::KIND_SET_COL;
    else if (pick < 75) c.k = psed_pkg::KIND_ALL_OFF;
    else if (pick < 93) c.k = psed_pkg::KIND_READ;
    else c.k = kind_code_t'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    if ($urandom_range(99) < 85) begin
      case (c.k)
        psed_pkg::KIND_SET_ROW: c.idx = idx_t'($urandom_range(1, NUM_ROWS));
        psed_pkg::KIND_SET_COL: c.idx = idx_t'($urandom_range(1, NUM_COLS));
        psed_pkg::KIND_READ:    c.idx = idx_t'($urandom_range(NUM_CHAN - 1));
        default: ;
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 10) c.lvl = '0;
    else if (pick < 35) c.lvl = lvl_t'($urandom_range(psed_pkg::LEVEL_FULL - 10, LEVEL_MAX));
    else c.lvl = lvl_t'($urandom_range(LEVEL_MAX));
    return c;
  endfunction

  // -------------------------------------------------------------------------
  // Receiver: random stall, or a long hold-off when one is requested
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_served != hold_reqs) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Checker: every taken result against the oldest expectation
  // -------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    drive_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected result word", 32'({column_levels, row_levels}), '0);
      end else begin
        exp_w = expected_words.pop_front();
        if (column_levels !== exp_w.cols)
          report_mismatch("column_levels", 32'(column_levels), 32'(exp_w.cols));
        if (row_levels !== exp_w.rows)
          report_mismatch("row_levels", 32'(row_levels), 32'(exp_w.rows));
        if (phase_value !== exp_w.phase)
          report_mismatch("phase_value", 32'(phase_value), 32'(exp_w.phase));
        if (rejected !== exp_w.rej)
          report_mismatch("rejected", 32'(rejected), 32'(exp_w.rej));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_words.size());
      $display("Verification failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Fresh table reads zero everywhere; out-of-range channels read zero too
  task automatic test_reset_reads();
    send_word(psed_pkg::KIND_READ, 5'd0, '0);
    send_word(psed_pkg::KIND_READ, idx_t'(NUM_CHAN - 1), lvl_t'(LEVEL_MAX));
    send_word(psed_pkg::KIND_READ, idx_t'(NUM_CHAN), '0);
    send_word(psed_pkg::KIND_READ, idx_t'(INDEX_MAX), lvl_t'(LEVEL_MAX));
    send_word(psed_pkg::KIND_TICK, '0, '0);
  endtask

  // First and last lines, saturation, and every rejected index edge
  task automatic test_line_sets();
    send_word(psed_pkg::KIND_SET_ROW, 5'd1, '0);
    send_word(psed_pkg::KIND_SET_ROW, idx_t'(NUM_ROWS), lvl_t'(LEVEL_MAX));
    send_word(psed_pkg::KIND_SET_ROW, 5'd0, 10'd500);
    send_word(psed_pkg::KIND_SET_ROW, idx_t'(NUM_ROWS + 1), 10'd500);
    send_word(psed_pkg::KIND_SET_COL, 5'd1, 10'd63);
    send_word(psed_pkg::KIND_SET_COL, idx_t'(NUM_COLS), lvl_t'(psed_pkg::LEVEL_FULL));
    send_word(psed_pkg::KIND_SET_COL, 5'd0, lvl_t'(LEVEL_MAX));
    send_word(psed_pkg::KIND_SET_COL, idx_t'(NUM_COLS + 1), 10'd300);
    send_word(psed_pkg::KIND_SET_COL, idx_t'(INDEX_MAX), 10'd300);
  endtask

  // Rounding edges just below and above a half step
  task automatic test_level_rounding();
    send_word(psed_pkg::KIND_SET_COL, 5'd3, 10'd62);
    send_word(psed_pkg::KIND_READ, 5'd2, '0);
    send_word(psed_pkg::KIND_SET_COL, 5'd3, 10'd937);
    send_word(psed_pkg::KIND_READ, 5'd2, '0);
    send_word(psed_pkg::KIND_SET_COL, 5'd3, 10'd938);
    send_word(psed_pkg::KIND_READ, 5'd2, '0);
  endtask

  // All-off realigns to column 1; ignored kinds leave everything alone
  task automatic test_all_off_and_spare();
    send_word(psed_pkg::KIND_SET_ROW, 5'd4, 10'd700);
    send_word(psed_pkg::KIND_ALL_OFF, idx_t'(INDEX_MAX), lvl_t'(LEVEL_MAX));
    send_word(KIND_SPARE_LO, 5'd4, 10'd700);
    send_word(KIND_SPARE_HI, idx_t'(INDEX_MAX), lvl_t'(LEVEL_MAX));
    send_word(psed_pkg::KIND_READ, idx_t'(NUM_COLS + 3), '0);
  endtask

  task automatic test_random_traffic(int count);
    drive_cmd_t c;
    repeat (count) begin
      c = random_cmd();
      send_word(c.k, c.idx, c.lvl);
    end
  endtask

  // Hold the output off for a long stretch while words keep coming, so the
  // pipe fills and the input stalls; then pause until all results are back
  task automatic test_output_holdoff(int count);
    drive_cmd_t c;
    hold_reqs++;
    repeat (count) begin
      c = random_cmd();
      send_word(c.k, c.idx, c.lvl);
    end
    wait_results_drained();
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    for (int ch = 0; ch < NUM_CHAN; ch++) phase_tab[ch] = '0;
    tick_pos = '0;
    drive_lv = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender light idling, receiver heavy
    send_idle_pct = 23;
    recv_idle_pct = 81;
    test_reset_reads();
    test_line_sets();
    test_level_rounding();
    test_all_off_and_spare();
    test_random_traffic(500);

    // sender heavy idling, receiver light
    send_idle_pct = 81;
    recv_idle_pct = 23;
    test_random_traffic(500);

    // no idling at all, plus the hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_holdoff(60);
    test_random_traffic(470);

    wait_results_drained();
    repeat (END_LATENCY) @(posedge clk);

    $display("Sent %0d words: %0d ticks, %0d line sets (%0d rejected), %0d reads, %0d other",
             words_sent, tick_count, set_count, reject_count, read_count, other_count);
    $display("Checked %0d results under three idle mixes and a %0d-cycle output hold-off",
             results_seen, HOLD_CYCLES);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               mismatch_count, expected_words.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ phase_shift_electrode_driver_top.f @@
hw/rtl/psed_pkg.sv
hw/rtl/psed_delta.sv
hw/rtl/psed_wave.sv
hw/rtl/phase_shift_electrode_driver_top.sv
verif/tb_top.sv
